// ===== hw/rtl/moving_average_filter_unit_defines.svh =====
// assertion macros for the moving average filter unit
// used by the top level only; no other dependencies
`ifndef MOVING_AVERAGE_FILTER_UNIT_DEFINES_SVH
`define MOVING_AVERAGE_FILTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// concurrent check on an explicit clock and active-low reset
`define MAF_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check on the block clock and reset
`define MAF_ASSERT(label, prop, msg) \
  `MAF_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`else

`define MAF_ASSERT_CLK(label, clk, rst_n, prop, msg)

`define MAF_ASSERT(label, prop, msg)

`endif

`endif

// ===== hw/rtl/maf_pkg.sv =====
// shared constants for the moving average filter unit
// window codes, shift amounts and register map; no dependencies
package maf_pkg;

  // window length select codes
  localparam logic [1:0] WIN_CODE_1   = 2'd0;
  localparam logic [1:0] WIN_CODE_16  = 2'd1;
  localparam logic [1:0] WIN_CODE_32  = 2'd2;
  localparam logic [1:0] WIN_CODE_128 = 2'd3;

  localparam int unsigned WIN_CODE_W = 2;
  localparam logic [WIN_CODE_W-1:0] WIN_CODE_RESET = WIN_CODE_16;

  // log2 of each window length
  localparam int unsigned SHIFT_W = 3;
  localparam logic [SHIFT_W-1:0] SHIFT_1   = 3'd0;
  localparam logic [SHIFT_W-1:0] SHIFT_16  = 3'd4;
  localparam logic [SHIFT_W-1:0] SHIFT_32  = 3'd5;
  localparam logic [SHIFT_W-1:0] SHIFT_128 = 3'd7;

  // register map
  localparam int unsigned PADDR_W = 2;
  localparam logic [PADDR_W-1:0] ADDR_WINDOW_CODE = 2'd0;
  localparam int unsigned PDATA_W = 32;

endpackage

// ===== hw/rtl/moving_average_filter_unit.sv =====
// moving average filter unit: boxcar average over records of audio samples
// depends on maf_pkg, maf_ram, maf_ptr and moving_average_filter_unit_defines.svh
//
// usage
// - input channel: sample_i / last_sample_i under in_valid_i / in_ready_o;
//   a transaction happens on a rising edge with valid and ready both high
// - output channel: average_o / last_out_o under out_valid_o / out_ready_i,
//   one result transaction for every input transaction, in order
// - average is floor(running sum / window); during warm-up the partial sum
//   is still divided by the full window
// - last_sample_i ends a record: sum, fill count and pointer restart after it
// - each result passes the read stage, then the output register
// - throughput: one transaction per cycle unless stalled; each sample takes one
//   ram write and one ram read (the sample one window back), issued at accept
//   and consumed in the read stage, so the ram's single read port sets the rate
// - when the receiver stalls, one sample waits in the read stage and one
//   result in the output register; in_ready_o drops only once both are full
// - reset: window code 16, sum, fill count and pointer cleared; the delay line
//   holds no reset, entries are read only after being written in the record
// - window_code write (apb, address 0) also restarts averaging; write only
//   while no transaction is in flight
`include "moving_average_filter_unit_defines.svh"

module moving_average_filter_unit
  import maf_pkg::*;
#(
  parameter int unsigned MaxWindow  = 128,
  parameter int unsigned SampleBits = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // apb configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready,
  // sample input
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SampleBits-1:0] sample_i,
  input  logic                  last_sample_i,
  // average output
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SampleBits-1:0] average_o,
  output logic                  last_out_o
);

  localparam int unsigned AW = $clog2(MaxWindow);
  localparam int unsigned LW = $clog2(MaxWindow + 1);
  // sum of up to MaxWindow samples never overflows this width
  localparam int unsigned SW = SampleBits + AW;

  // configuration register
  logic [WIN_CODE_W-1:0] win_code_q;
  logic                  cfg_we;

  assign cfg_we = psel && penable && pwrite && (paddr == ADDR_WINDOW_CODE);
  assign pready = 1'b1;
  assign prdata = PDATA_W'(win_code_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_code_q <= WIN_CODE_RESET;
    end else if (cfg_we) begin
      win_code_q <= pwdata[WIN_CODE_W-1:0];
    end
  end

  // windows over the delay line depth drop to the largest that fits, at least 16
  logic [SHIFT_W-1:0] shift;
  logic [LW-1:0]      win_len;

  always_comb begin
    case (win_code_q)
      WIN_CODE_1:   shift = SHIFT_1;
      WIN_CODE_16:  shift = SHIFT_16;
      WIN_CODE_32:  shift = (MaxWindow >= 32) ? SHIFT_32 : SHIFT_16;
      WIN_CODE_128: begin
        if (MaxWindow >= 128) begin
          shift = SHIFT_128;
        end else if (MaxWindow >= 32) begin
          shift = SHIFT_32;
        end else begin
          shift = SHIFT_16;
        end
      end
      default:      shift = SHIFT_16;
    endcase
    win_len = LW'(1) << shift;
  end

  // handshake and stage control
  logic in_accept;
  logic s1_valid_q;
  logic s1_adv;
  logic out_valid_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_accept  = in_valid_i && in_ready_o;

  // pointer and fill tracking
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          sub_en;

  maf_ptr #(
    .MaxWindow (MaxWindow)
  ) u_ptr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .last_i    (last_sample_i),
    .clear_i   (cfg_we),
    .win_len_i (win_len),
    .wr_addr_o (wr_addr),
    .rd_addr_o (rd_addr),
    .sub_en_o  (sub_en)
  );

  // delay line: new sample written and old sample read in the accept cycle;
  // at full depth both hit the same entry and read-first returns the old one
  logic [SampleBits-1:0] old_sample;

  maf_ram #(
    .Width (SampleBits),
    .Depth (MaxWindow)
  ) u_delay_ram (
    .clk_i   (clk_i),
    .we_i    (in_accept),
    .waddr_i (wr_addr),
    .wdata_i (sample_i),
    .re_i    (in_accept),
    .raddr_i (rd_addr),
    .rdata_o (old_sample)
  );

  // read stage: holds the sample while the ram data comes back
  logic [SampleBits-1:0] s1_sample_q;
  logic                  s1_last_q;
  logic                  s1_sub_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_sample_q <= sample_i;
      s1_last_q   <= last_sample_i;
      s1_sub_q    <= sub_en;
    end
  end

  // running sum update, one add and one subtract per sample
  logic signed [SW-1:0] sum_q, sum_d;
  logic signed [SW-1:0] sum_new;
  logic signed [SW-1:0] add_term;
  logic signed [SW-1:0] sub_term;
  logic signed [SW-1:0] avg_full;

  always_comb begin
    add_term = SW'($signed(s1_sample_q));
    sub_term = s1_sub_q ? SW'($signed(old_sample)) : '0;
    sum_new  = sum_q + add_term - sub_term;
    // arithmetic shift gives floor division by the window
    avg_full = sum_new >>> shift;
    sum_d    = sum_q;
    if (cfg_we) begin
      sum_d = '0;
    end else if (s1_adv) begin
      sum_d = s1_last_q ? '0 : sum_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  // output register
  logic [SampleBits-1:0] average_q;
  logic                  last_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      average_q  <= avg_full[SampleBits-1:0];
      last_out_q <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign average_o   = average_q;
  assign last_out_o  = last_out_q;

  // checks

  // a full read stage behind a stalled output must block new samples
  `MAF_ASSERT(a_stall_blocks_input,
    s1_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o,
    "sample accepted while read stage and output are both stalled")

  // the first sample of a new record never subtracts from the delay line
  `MAF_ASSERT(a_record_restart,
    in_accept && last_sample_i |=> !sub_en,
    "subtract enabled right after end of record")

  // a result only appears after the read stage held a sample
  `MAF_ASSERT(a_result_source,
    $rose(out_valid_q) |-> $past(s1_valid_q),
    "result shown without a sample in the read stage")

endmodule

// ===== hw/rtl/maf_ram.sv =====
// generic single-write, single-read ram with registered read data
// read-first on a same-address write; no dependencies
module maf_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/maf_ptr.sv =====
// write pointer, fill count and tail address for the delay line
// imports maf_pkg but uses none of it; widths come from parameters
module maf_ptr
  import maf_pkg::*;
#(
  parameter int unsigned MaxWindow = 128
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic                             last_i,
  input  logic                             clear_i,
  input  logic [$clog2(MaxWindow+1)-1:0]   win_len_i,
  output logic [$clog2(MaxWindow)-1:0]     wr_addr_o,
  output logic [$clog2(MaxWindow)-1:0]     rd_addr_o,
  output logic                             sub_en_o
);

  localparam int unsigned AW = $clog2(MaxWindow);
  localparam int unsigned LW = $clog2(MaxWindow + 1);

  logic [AW-1:0] wp_q, wp_d;
  logic [LW-1:0] fill_q, fill_d;
  logic [LW:0]   wp_ext, win_ext, tail_ext;

  // tail entry is one window behind the write pointer, modulo the depth
  always_comb begin
    wp_ext  = (LW+1)'(wp_q);
    win_ext = {1'b0, win_len_i};
    if (wp_ext >= win_ext) begin
      tail_ext = wp_ext - win_ext;
    end else begin
      tail_ext = wp_ext + (LW+1)'(MaxWindow) - win_ext;
    end
  end

  assign rd_addr_o = tail_ext[AW-1:0];
  assign wr_addr_o = wp_q;
  assign sub_en_o  = (fill_q >= win_len_i);

  always_comb begin
    wp_d   = wp_q;
    fill_d = fill_q;
    if (clear_i) begin
      wp_d   = '0;
      fill_d = '0;
    end else if (accept_i) begin
      if (last_i) begin
        wp_d   = '0;
        fill_d = '0;
      end else begin
        wp_d = (wp_q == AW'(MaxWindow - 1)) ? '0 : wp_q + AW'(1);
        if (fill_q < LW'(MaxWindow)) begin
          fill_d = fill_q + LW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
    end else begin
      wp_q   <= wp_d;
      fill_q <= fill_d;
    end
  end

endmodule

// ===== verif/tb_moving_average_filter_unit.sv =====
// self-checking testbench for moving_average_filter_unit: boxcar average per record
// depends on maf_pkg and the rtl of the unit; random stimulus with valid/ready idling
// and apb window changes, checked against a running-sum predictor in this file
`timescale 1ns / 1ps

module tb_moving_average_filter_unit
  import maf_pkg::*;
;

  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned HIST_DEPTH   = 128;
  // cycles to let the pipeline settle before a register write or the end
  localparam int unsigned SETTLE_WAIT  = 8;
  // cycles without any transaction before the run is declared hung
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned PHASE_ITEMS  = 235;
  localparam int unsigned NUM_PHASES   = 8;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // one input transaction and one result transaction
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_flag;
  } sample_txn_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    logic                       last_out;
  } avg_txn_t;

  // content of a generated record
  typedef enum int unsigned {
    REC_NOISE,
    REC_FULL_POS,
    REC_FULL_NEG,
    REC_QUIET,
    REC_RAILS
  } rec_style_e;

  // dut ports; every input driven to a known value from time zero
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [PADDR_W-1:0]  paddr         = '0;
  logic [PDATA_W-1:0]  pwdata        = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [SAMPLE_W-1:0] sample_i      = '0;
  logic                last_sample_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [SAMPLE_W-1:0] average_o;
  logic                last_out_o;

  moving_average_filter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_i      (sample_i),
    .last_sample_i (last_sample_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .average_o     (average_o),
    .last_out_o    (last_out_o)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // ---------------------------------------------------------------------------
  // running-sum predictor: own copy of the delay line, sum, fill and window
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] hist_mem [HIST_DEPTH];
  int                         acc_sum;
  int unsigned                fill_cnt;
  int unsigned                wr_ptr;
  logic [WIN_CODE_W-1:0]      win_sel;

  // log2 of the window length for a window code
  function automatic int unsigned win_shift(input logic [WIN_CODE_W-1:0] code);
    case (code)
      WIN_CODE_1:  return SHIFT_1;
      WIN_CODE_16: return SHIFT_16;
      WIN_CODE_32: return SHIFT_32;
      default:     return SHIFT_128;
    endcase
  endfunction

  function automatic void restart_record();
    acc_sum  = 0;
    fill_cnt = 0;
    wr_ptr   = 0;
  endfunction

  // adds one sample, drops the one a window back once the window is full,
  // and returns floor(sum / window) even while the window is still filling
  function automatic avg_txn_t predict_average(input logic signed [SAMPLE_W-1:0] x,
                                               input logic last_flag);
    int unsigned sh;
    int unsigned w;
    avg_txn_t    res;
    sh = win_shift(win_sel);
    w  = 1 << sh;
    if (fill_cnt >= w) begin
      acc_sum = acc_sum + x - hist_mem[(wr_ptr + HIST_DEPTH - w) % HIST_DEPTH];
    end else begin
      acc_sum = acc_sum + x;
    end
    hist_mem[wr_ptr] = x;
    wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
    if (fill_cnt < HIST_DEPTH) fill_cnt++;
    // arithmetic shift of a signed sum rounds toward minus infinity
    res.average  = SAMPLE_W'(acc_sum >>> sh);
    res.last_out = last_flag;
    if (last_flag) restart_record();
    return res;
  endfunction

  initial begin
    foreach (hist_mem[i]) hist_mem[i] = '0;
    restart_record();
    win_sel = WIN_CODE_RESET;
  end

  // ---------------------------------------------------------------------------
  // shared bookkeeping
  // ---------------------------------------------------------------------------
  sample_txn_t sample_pend_q[$];   // samples waiting to be driven
  avg_txn_t    avg_expect_q[$];    // predicted averages not yet seen
  int unsigned in_gap_max;         // per-phase idle range of the sender
  int unsigned out_stall_max;      // per-phase stall range of the receiver
  int unsigned fail_cnt;
  int unsigned n_samples;
  int unsigned n_averages;
  int unsigned n_records;
  logic [3:0]  win_seen;           // one bit per window code exercised

  initial begin
    in_gap_max    = 0;
    out_stall_max = 0;
    fail_cnt      = 0;
    n_samples     = 0;
    n_averages    = 0;
    n_records     = 0;
    win_seen      = '0;
  end

  // ---------------------------------------------------------------------------
  // input driver: presents queued samples, idles a random number of cycles
  // after each one, and runs the predictor on every accepted transaction
  // ---------------------------------------------------------------------------
  int unsigned in_gap_left = 0;
  sample_txn_t drv_item;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        avg_expect_q.push_back(predict_average(sample_i, last_sample_i));
        n_samples++;
        if (last_sample_i) n_records++;
        win_seen[win_sel] = 1'b1;
      end
      // the slot is free unless a transaction is still waiting for ready
      if (!in_valid_i || in_ready_o) begin
        if (in_gap_left != 0) begin
          in_gap_left--;
          in_valid_i <= 1'b0;
        end else if (sample_pend_q.size() != 0) begin
          drv_item = sample_pend_q.pop_front();
          sample_i      <= drv_item.sample;
          last_sample_i <= drv_item.last_flag;
          in_valid_i    <= 1'b1;
          in_gap_left = $urandom_range(0, in_gap_max);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output monitor: checks every result transaction against the oldest
  // prediction, then holds ready low for a random number of cycles
  // ---------------------------------------------------------------------------
  int unsigned out_stall_left = 0;
  avg_txn_t    mon_want;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_averages++;
        if (avg_expect_q.size() == 0) begin
          $error("result with no sample pending: average %0d last_out %0b",
                 $signed(average_o), last_out_o);
          fail_cnt++;
        end else begin
          mon_want = avg_expect_q.pop_front();
          if (average_o !== mon_want.average) begin
            $error("average: expected %0d, actual %0d",
                   $signed(mon_want.average), $signed(average_o));
            fail_cnt++;
          end
          if (last_out_o !== mon_want.last_out) begin
            $error("last_out: expected %0b, actual %0b", mon_want.last_out, last_out_o);
            fail_cnt++;
          end
        end
        out_stall_left = $urandom_range(0, out_stall_max);
      end
      if (out_stall_left != 0) begin
        out_stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: any transaction on either channel or the apb port restarts it
  // ---------------------------------------------------------------------------
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || psel || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_sample(input logic signed [SAMPLE_W-1:0] s,
                                       input logic last_flag);
    sample_pend_q.push_back('{sample: s, last_flag: last_flag});
  endfunction

  // wait until every sample is accepted and every average seen, then let the
  // pipeline run empty
  task automatic settle();
    do @(negedge clk_i);
    while (sample_pend_q.size() != 0 || in_valid_i || avg_expect_q.size() != 0);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  // apb write of the window code followed by a read back; the write also
  // restarts averaging, so the predictor restarts at the same edge
  task automatic write_window(input logic [WIN_CODE_W-1:0] code);
    logic [PDATA_W-1:0] wdata;
    wdata = {PDATA_W'($urandom)} & ~PDATA_W'(2 ** WIN_CODE_W - 1);
    wdata = wdata | PDATA_W'(code);
    // setup
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_WINDOW_CODE;
    pwdata  <= wdata;
    // access
    @(posedge clk_i);
    penable <= 1'b1;
    // register takes the value at this edge
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    win_sel = code;
    restart_record();
    // read back
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[WIN_CODE_W-1:0] !== code) begin
      $error("window_code: expected %0d, actual %0d", code, prdata[WIN_CODE_W-1:0]);
      fail_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // records of random length and content; the budget may cut the last one
  // short, leaving it open across the next window change
  task automatic queue_records(input int unsigned budget, input logic [WIN_CODE_W-1:0] code);
    int unsigned                left;
    int unsigned                len;
    int unsigned                w;
    logic                       open_end;
    logic                       lf;
    logic signed [SAMPLE_W-1:0] s;
    rec_style_e                 style;
    left = budget;
    w    = 1 << win_shift(code);
    while (left != 0) begin
      // mostly records past a full window, some very short ones
      if ($urandom_range(0, 6) == 0) len = $urandom_range(1, 3);
      else len = $urandom_range(w, 3 * w + 4);
      open_end = (len > left);
      if (open_end) len = left;
      style = rec_style_e'($urandom_range(REC_NOISE, REC_RAILS));
      for (int unsigned i = 0; i < len; i++) begin
        case (style)
          REC_NOISE:    s = SAMPLE_W'($urandom);
          REC_FULL_POS: s = SAMPLE_MAX;
          REC_FULL_NEG: s = SAMPLE_MIN;
          REC_QUIET:    s = SAMPLE_W'(int'($urandom_range(0, 15)) - 8);
          default:      s = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
        endcase
        // occasional stray end flag breaks a record early
        lf = ((i == len - 1) && !open_end) || ($urandom_range(0, 63) == 0);
        queue_sample(s, lf);
      end
      left -= len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  logic [WIN_CODE_W-1:0] phase_code;

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    in_gap_max    = 9;
    out_stall_max = 9;

    // reset window of 16: extremes, alternating bit patterns, end of record
    @(negedge clk_i);
    queue_sample(SAMPLE_MAX, 1'b0);
    queue_sample(SAMPLE_MIN, 1'b0);
    queue_sample(16'sd0, 1'b0);
    queue_sample(-16'sd1, 1'b0);
    queue_sample(16'sd1, 1'b0);
    queue_sample(16'sh5555, 1'b0);
    queue_sample(16'shaaaa, 1'b0);
    queue_sample(-16'sd1, 1'b1);
    settle();

    // window of one: the average is the sample itself
    write_window(WIN_CODE_1);
    @(negedge clk_i);
    queue_sample(SAMPLE_MAX, 1'b0);
    queue_sample(SAMPLE_MIN, 1'b0);
    queue_sample(-16'sd1, 1'b0);
    queue_sample(16'sd1, 1'b1);
    settle();

    // longest window: warm-up sums divided by 128, then a fresh record left
    // open so the next write changes the window mid-record
    write_window(WIN_CODE_128);
    @(negedge clk_i);
    queue_sample(SAMPLE_MAX, 1'b0);
    queue_sample(SAMPLE_MIN, 1'b0);
    queue_sample(-16'sd2, 1'b0);
    queue_sample(16'sd5, 1'b1);
    queue_sample(-16'sd1, 1'b0);
    queue_sample(16'sd100, 1'b0);
    queue_sample(-16'sd100, 1'b0);
    settle();

    // random phases: every window, with and without idling on each side
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       phase_code = WIN_CODE_32;
        1:       phase_code = WIN_CODE_16;
        2:       phase_code = WIN_CODE_128;
        3:       phase_code = WIN_CODE_1;
        4:       phase_code = WIN_CODE_128;
        5:       phase_code = WIN_CODE_32;
        default: phase_code = WIN_CODE_W'($urandom_range(0, 3));
      endcase
      write_window(phase_code);
      in_gap_max    = (p % 4 == 1 || p % 4 == 2) ? 9 : 0;
      out_stall_max = (p % 4 == 1 || p % 4 == 3) ? 9 : 0;
      @(negedge clk_i);
      queue_records(PHASE_ITEMS, phase_code);
      settle();
    end

    $display("covered %0d samples in %0d closed records, %0d averages checked",
             n_samples, n_records, n_averages);
    $display("window codes used (bit per code): %b", win_seen);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
